// ----- rtl/core/fsgd_pkg.sv -----
package fsgd_pkg;

	// field widths
	localparam int PIX_W      = 8;
	localparam int ERR_W      = 8;
	localparam int IW_W       = 11;
	localparam int IH_W       = 16;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [IW_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IH_W-1:0] HEIGHT_RESET = 16'd480;

	// register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// where the error from the row above comes from
	localparam logic [1:0] SRC_MEM  = 2'd0;
	localparam logic [1:0] SRC_TAIL = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;

	// pixel levels
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] PIX_THRESH = 8'd127;

	// diffusion weights, in sixteenths
	localparam logic [2:0] K_RIGHT       = 3'd7;
	localparam logic [2:0] K_BELOW_RIGHT = 3'd1;
	localparam logic [2:0] K_BELOW       = 3'd5;
	localparam logic [2:0] K_BELOW_LEFT  = 3'd3;

	typedef logic signed [ERR_W-1:0] err_t;

	// per-pixel control carried into the compute stage
	typedef struct packed {
		logic       last_col;
		logic       last_row;
		logic       first_col;
		logic       bank;
		logic [1:0] src;
	} ctl_t;

	// e * k / 16, truncated toward zero
	function automatic err_t share(input err_t e, input logic [2:0] k);
		logic [ERR_W-1:0] mag;
		logic [ERR_W+2:0] prod;
		logic [ERR_W-1:0] part;
		mag  = e[ERR_W-1] ? ERR_W'(~e + 1'b1) : ERR_W'(e);
		prod = (ERR_W+3)'(mag) * (ERR_W+3)'(k);
		part = ERR_W'(prod >> 4);
		share = e[ERR_W-1] ? err_t'(~part + 1'b1) : err_t'(part);
	endfunction

endpackage

// ----- rtl/core/floyd_steinberg_gray_dither.sv -----
// A pixel taken at the input is registered in the compute stage and then in the output
// register before it is shown; a stall of the output can hold it in between.
// Throughput: one pixel per clock while the output is not stalled, sustained across
// row and frame ends; both row error buffers share one RAM, bank bit on top.
// Reset clears counters, handshake state and the running error registers, and
// loads width 640 / height 480. The RAM is not swept: rows are tracked so that
// unwritten entries are never used, and the first row of a frame reads zero error.
module floyd_steinberg_gray_dither #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fsgd_pkg::PIX_W-1:0]      pixel,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fsgd_pkg::PIX_W-1:0]      out_pixel,
	output logic                            end_of_frame,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [fsgd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fsgd_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = CW + 1;
	localparam int XW = (CW + 1 > IW_W) ? CW + 1 : IW_W;
	localparam int HW = IH_W + 1;
	localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

	// configuration
	logic [IW_W-1:0] iw_q;
	logic [IH_W-1:0] ih_q;

	// front counters
	logic [CW-1:0]   col_q;
	logic [IH_W-1:0] row_q;
	logic            bank_q;
	logic [CW-1:0]   prev_end_q;

	// compute stage
	logic            s1_valid_q;
	ctl_t            ctl_s1;
	logic [CW-1:0]   col_s1;
	logic [PIX_W-1:0] pixel_s1;

	// running error
	err_t            rc_q;
	err_t            a_prev_q;
	err_t            a_cur_q;
	err_t            tail_q;

	// last RAM write, for forwarding
	logic            lw_en_q;
	logic [AW-1:0]   lw_addr_q;
	err_t            lw_data_q;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             eof_q;

	logic             in_fire;
	logic             s1_adv;
	logic             last_col;
	logic             last_row;
	logic [1:0]       src;
	ctl_t             ctl_in;

	logic [AW-1:0]    ram_rd_addr;
	logic [ERR_W-1:0] ram_rd_data;
	logic             ram_wr_en;
	logic [AW-1:0]    ram_wr_addr;
	err_t             ram_wr_data;

	logic [AW-1:0]    rd_addr_s1;
	logic             fwd;
	err_t             now_err;
	logic signed [9:0] adj;
	logic [PIX_W-1:0] adj_c;
	logic             white;
	err_t             err;
	logic             diffuse;
	err_t             s_right;
	err_t             s_below_right;
	err_t             s_below;
	err_t             s_below_left;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= WIDTH_RESET;
			ih_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  iw_q <= cfg_data[IW_W-1:0];
				CFG_HEIGHT: ih_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// position of the incoming pixel
	assign last_col = (XW'(col_q) + XW'(1) >= XW'(iw_q)) || (col_q == COL_LAST);
	assign last_row = (HW'(row_q) + HW'(1) >= HW'(ih_q));

	// row above: none on the first row, tail register at its last column,
	// nothing written beyond it
	always_comb begin
		if (row_q == '0) begin
			src = SRC_ZERO;
		end else if (col_q > prev_end_q) begin
			src = SRC_ZERO;
		end else if (col_q == prev_end_q) begin
			src = SRC_TAIL;
		end else begin
			src = SRC_MEM;
		end
	end

	always_comb begin
		ctl_in.last_col  = last_col;
		ctl_in.last_row  = last_row;
		ctl_in.first_col = (col_q == '0);
		ctl_in.bank      = bank_q;
		ctl_in.src       = src;
	end

	assign ram_rd_addr = {bank_q, col_q};

	// front counters and bank swap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			bank_q     <= 1'b0;
			prev_end_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q      <= '0;
				prev_end_q <= col_q;
				bank_q     <= ~bank_q;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1   <= ctl_in;
			col_s1   <= col_q;
			pixel_s1 <= pixel;
		end
	end

	// error from the row above, with bypass of a write made as it was read
	assign rd_addr_s1 = {ctl_s1.bank, col_s1};
	assign fwd        = lw_en_q && (lw_addr_q == rd_addr_s1);

	always_comb begin
		case (ctl_s1.src)
			SRC_MEM:  now_err = fwd ? lw_data_q : err_t'(ram_rd_data);
			SRC_TAIL: now_err = tail_q;
			default:  now_err = '0;
		endcase
	end

	// adjust, clamp, threshold
	assign adj = $signed({2'b00, pixel_s1}) + 10'(now_err) + 10'(rc_q);

	always_comb begin
		if (adj < 0) begin
			adj_c = PIX_BLACK;
		end else if (adj > 10'sd255) begin
			adj_c = PIX_WHITE;
		end else begin
			adj_c = adj[PIX_W-1:0];
		end
	end

	assign white = adj_c > PIX_THRESH;
	assign err   = white ? err_t'({1'b0, adj_c} - {1'b0, PIX_WHITE}) : err_t'(adj_c);

	// shares
	assign diffuse       = !ctl_s1.last_row && !ctl_s1.first_col && !ctl_s1.last_col;
	assign s_right       = diffuse ? share(err, K_RIGHT) : '0;
	assign s_below_right = diffuse ? share(err, K_BELOW_RIGHT) : '0;
	assign s_below       = diffuse ? share(err, K_BELOW) : '0;
	assign s_below_left  = diffuse ? share(err, K_BELOW_LEFT) : '0;

	// the column to the left is complete once this pixel adds its share
	assign ram_wr_en   = s1_adv && !ctl_s1.first_col;
	assign ram_wr_addr = {~ctl_s1.bank, col_s1 - 1'b1};
	assign ram_wr_data = err_t'(a_prev_q + s_below_left);

	// sliding window over the next row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q     <= '0;
			a_prev_q <= '0;
			a_cur_q  <= '0;
		end else if (s1_adv) begin
			rc_q <= s_right;
			if (ctl_s1.last_col) begin
				a_prev_q <= '0;
				a_cur_q  <= '0;
			end else begin
				a_prev_q <= err_t'(a_cur_q + s_below);
				a_cur_q  <= s_below_right;
			end
		end
	end

	// last column of the next row stays in a register
	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.last_col) begin
			tail_q <= a_cur_q;
		end
	end

	// last write tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_en_q <= 1'b0;
		end else if (ram_wr_en) begin
			lw_en_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_wr_en) begin
			lw_addr_q <= ram_wr_addr;
			lw_data_q <= ram_wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pixel_q <= white ? PIX_WHITE : PIX_BLACK;
			eof_q       <= ctl_s1.last_col && ctl_s1.last_row;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pixel    = out_pixel_q;
	assign end_of_frame = eof_q;

	// both row buffers in one RAM, bank bit on top
	fsgd_ram #(
		.WIDTH (ERR_W),
		.DEPTH (2 ** AW)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (in_fire),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// output is always binary
	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pixel == PIX_WHITE || out_pixel == PIX_BLACK))
		else $error("dithered word not black or white");

	// window and carry are empty after a row ends
	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctl_s1.last_col) |=> (a_prev_q == '0 && a_cur_q == '0 && rc_q == '0))
		else $error("error window not cleared at row end");

	// frame end returns both counters to zero
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_col && last_row) |=> (row_q == '0 && col_q == '0))
		else $error("counters not reset at frame end");

	// a stalled pixel keeps the RAM word it uses
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv && ctl_s1.src == SRC_MEM && !fwd) |=> $stable(ram_rd_data))
		else $error("RAM read data changed under a stalled pixel");

endmodule

// ----- rtl/core/fsgd_ram.sv -----
module fsgd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
